@@ hdl/msr_pkg.sv @@
// Shared types, widths, mode codes and the saturation helper for the
// multitrace sample reduction block. No dependencies.
`timescale 1ns / 1ps

package msr_pkg;

  localparam int LANES       = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int CNT_BITS    = 4;                        // traces_in_use field
  localparam int N_W         = $clog2(LANES + 1);        // clamped trace count
  localparam int SUM_W       = SAMPLE_BITS + $clog2(LANES);
  localparam int SAT_W       = SUM_W + 2;
  localparam int GRP         = 4;                        // lanes per reduction group
  localparam int GROUPS      = (LANES + GRP - 1) / GRP;
  localparam int DIV_K       = SUM_W;                    // reciprocal scale
  localparam int RECIP_W     = DIV_K + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int MODE_W      = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic [N_W-1:0]                cnt_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_DEBIAS = 3'd0,
    MODE_MEAN   = 3'd1,
    MODE_MIN    = 3'd2,
    MODE_MAX    = 3'd3,
    MODE_DIFF   = 3'd4
  } mode_t;

  // partial or full reduction of a set of lanes
  typedef struct packed {
    sum_t    sum;
    sample_t mn;
    sample_t mx;
  } grp_res_t;

  localparam sample_t SAMPLE_MAX_C = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN_C = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  function automatic sample_t sat_sample(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(SAMPLE_MAX_C);
    lo = SAT_W'(SAMPLE_MIN_C);
    if (v > hi) return SAMPLE_MAX_C;
    else if (v < lo) return SAMPLE_MIN_C;
    else return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

@@ hdl/msr_group.sv @@
// One reduction group: sum, min and max over up to GRP active lanes, registered.
// Depends on msr_pkg.
`timescale 1ns / 1ps

module msr_group import msr_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  sample_t        smp [GRP],
  input  logic [GRP-1:0] act,
  output grp_res_t       res
);

  grp_res_t res_next;

  always_comb begin
    res_next.sum = '0;
    res_next.mn  = SAMPLE_MAX_C;
    res_next.mx  = SAMPLE_MIN_C;
    for (int j = 0; j < GRP; j++) begin
      if (act[j]) begin
        res_next.sum = res_next.sum + SUM_W'(smp[j]);
        if (smp[j] < res_next.mn) res_next.mn = smp[j];
        if (smp[j] > res_next.mx) res_next.mx = smp[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) res <= res_next;
  end

endmodule

@@ hdl/msr_merge.sv @@
// Merges the group partials into the column sum, min and max, registered.
// Depends on msr_pkg.
`timescale 1ns / 1ps

module msr_merge import msr_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  grp_res_t gres [GROUPS],
  output grp_res_t total
);

  grp_res_t total_next;

  always_comb begin
    total_next.sum = '0;
    total_next.mn  = SAMPLE_MAX_C;
    total_next.mx  = SAMPLE_MIN_C;
    for (int g = 0; g < GROUPS; g++) begin
      total_next.sum = total_next.sum + gres[g].sum;
      if (gres[g].mn < total_next.mn) total_next.mn = gres[g].mn;
      if (gres[g].mx > total_next.mx) total_next.mx = gres[g].mx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) total <= total_next;
  end

endmodule

@@ hdl/msr_mean_div.sv @@
// Column mean: sum / count truncated toward zero, by reciprocal multiply
// plus one-step correction over two register stages. Depends on msr_pkg.
`timescale 1ns / 1ps

module msr_mean_div import msr_pkg::*; (
  input  logic    clk,
  input  logic    en_mul,
  input  logic    en_fix,
  input  sum_t    sum,
  input  cnt_t    n,
  output sample_t mean
);

  localparam int QN_W = SUM_W + N_W;

  // floor(2^K / n); entry 0 never used
  logic [RECIP_W-1:0] recip_tab [LANES+1];

  assign recip_tab[0] = '0;
  for (genvar i = 1; i <= LANES; i++) begin : g_recip
    localparam logic [RECIP_W-1:0] RV = RECIP_W'((64'd1 << DIV_K) / i);
    assign recip_tab[i] = RV;
  end

  logic [SUM_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  mag_r;
  logic              neg_r;
  cnt_t              n_r;

  assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod  <= PROD_W'(mag) * PROD_W'(recip_tab[n]);
      mag_r <= mag;
      neg_r <= sum[SUM_W-1];
      n_r   <= n;
    end
  end

  // estimate is exact or one low
  logic [SUM_W-1:0] q0;
  logic [QN_W-1:0]  rem;
  logic [SUM_W-1:0] q;
  logic [SUM_W-1:0] mean_full;

  always_comb begin
    q0        = prod[DIV_K +: SUM_W];
    rem       = QN_W'(mag_r) - QN_W'(q0) * QN_W'(n_r);
    q         = (rem >= QN_W'(n_r)) ? q0 + SUM_W'(1) : q0;
    mean_full = neg_r ? -q : q;
  end

  always_ff @(posedge clk) begin
    if (en_fix) mean <= mean_full[SAMPLE_BITS-1:0];
  end

endmodule

@@ hdl/multitrace_sample_reduction.sv @@
// Top level of the multitrace sample reduction block: input register, group
// reduction, merge, mean divider and the per-lane result stage.
// Depends on msr_pkg, msr_group, msr_merge, msr_mean_div.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): one sample column per transfer, lanes
//   0..LANES-1, traces_in_use (0 taken as 1, above LANES taken as LANES) and
//   the end_of_trace marker.
//   Output channel (out_valid/out_ready): one result per column, in order.
//   Debias gives every lane in use its sample minus the column mean; mean,
//   min, max and diff give one value in lane 0. Unused lanes read zero.
//   cfg_wr_en/cfg_wr_data write the mode register; write it only while idle.
// Throughput: one column per cycle while out_ready is high; six pipeline
//   stages, each one register deep, set by the mean path (input register,
//   group sum, merge, reciprocal multiply, correction, result).
// Reset (rst, synchronous): empties the pipeline and sets mode to debias.
// Stall: when out_ready is low the result holds; earlier stages keep filling
//   until every stage is occupied, and only then does in_ready drop.
module multitrace_sample_reduction import msr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [MODE_W-1:0]     cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_BITS-1:0] lane_sample_0,
  input  logic [SAMPLE_BITS-1:0] lane_sample_1,
  input  logic [SAMPLE_BITS-1:0] lane_sample_2,
  input  logic [SAMPLE_BITS-1:0] lane_sample_3,
  input  logic [SAMPLE_BITS-1:0] lane_sample_4,
  input  logic [SAMPLE_BITS-1:0] lane_sample_5,
  input  logic [SAMPLE_BITS-1:0] lane_sample_6,
  input  logic [SAMPLE_BITS-1:0] lane_sample_7,
  input  logic [CNT_BITS-1:0]   traces_in_use,
  input  logic                  end_of_trace,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_BITS-1:0] out_value_0,
  output logic [SAMPLE_BITS-1:0] out_value_1,
  output logic [SAMPLE_BITS-1:0] out_value_2,
  output logic [SAMPLE_BITS-1:0] out_value_3,
  output logic [SAMPLE_BITS-1:0] out_value_4,
  output logic [SAMPLE_BITS-1:0] out_value_5,
  output logic [SAMPLE_BITS-1:0] out_value_6,
  output logic [SAMPLE_BITS-1:0] out_value_7,
  output logic [CNT_BITS-1:0]   values_valid,
  output logic                  end_of_output
);

  localparam int STAGES = 6;

  // ---------------------------------------------------------------------
  // Mode register
  // ---------------------------------------------------------------------
  mode_t mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DEBIAS;
    end else if (cfg_wr_en) begin
      mode <= mode_t'(cfg_wr_data);
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control: stage k loads when it is empty or stage k+1 loads.
  // vld[STAGES-1] is the output register.
  // ---------------------------------------------------------------------
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: input register, trace count clamped to 1..LANES
  // ---------------------------------------------------------------------
  sample_t lane_in [LANES];
  cnt_t    n_in;

  assign lane_in[0] = lane_sample_0;
  assign lane_in[1] = lane_sample_1;
  assign lane_in[2] = lane_sample_2;
  assign lane_in[3] = lane_sample_3;
  assign lane_in[4] = lane_sample_4;
  assign lane_in[5] = lane_sample_5;
  assign lane_in[6] = lane_sample_6;
  assign lane_in[7] = lane_sample_7;

  always_comb begin
    if (traces_in_use == '0) begin
      n_in = N_W'(1);
    end else if (int'(traces_in_use) > LANES) begin
      n_in = N_W'(LANES);
    end else begin
      n_in = N_W'(traces_in_use);
    end
  end

  // sample, count, marker and mode travel alongside the reductions
  sample_t s1_smp [LANES];
  sample_t s2_smp [LANES];
  sample_t s3_smp [LANES];
  sample_t s4_smp [LANES];
  sample_t s5_smp [LANES];
  cnt_t    s1_n, s2_n, s3_n, s4_n, s5_n;
  logic    s1_eot, s2_eot, s3_eot, s4_eot, s5_eot;
  mode_t   s1_mode, s2_mode, s3_mode, s4_mode, s5_mode;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_smp  <= lane_in;
      s1_n    <= n_in;
      s1_eot  <= end_of_trace;
      s1_mode <= mode;
    end
    if (en[1]) begin
      s2_smp  <= s1_smp;
      s2_n    <= s1_n;
      s2_eot  <= s1_eot;
      s2_mode <= s1_mode;
    end
    if (en[2]) begin
      s3_smp  <= s2_smp;
      s3_n    <= s2_n;
      s3_eot  <= s2_eot;
      s3_mode <= s2_mode;
    end
    if (en[3]) begin
      s4_smp  <= s3_smp;
      s4_n    <= s3_n;
      s4_eot  <= s3_eot;
      s4_mode <= s3_mode;
    end
    if (en[4]) begin
      s5_smp  <= s4_smp;
      s5_n    <= s4_n;
      s5_eot  <= s4_eot;
      s5_mode <= s4_mode;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: per-group partial sum/min/max. Lanes at or above the trace
  // count, and padding past LANES, are masked out.
  // ---------------------------------------------------------------------
  grp_res_t gres [GROUPS];

  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    sample_t        grp_smp [GRP];
    logic [GRP-1:0] grp_act;

    for (genvar j = 0; j < GRP; j++) begin : g_lane
      if (g * GRP + j < LANES) begin : g_real
        assign grp_smp[j] = s1_smp[g*GRP+j];
        assign grp_act[j] = N_W'(g * GRP + j) < s1_n;
      end else begin : g_pad
        assign grp_smp[j] = '0;
        assign grp_act[j] = 1'b0;
      end
    end

    msr_group u_group (
      .clk (clk),
      .en  (en[1]),
      .smp (grp_smp),
      .act (grp_act),
      .res (gres[g])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 3: merged column sum, min, max
  // ---------------------------------------------------------------------
  grp_res_t s3_tot;

  msr_merge u_merge (
    .clk   (clk),
    .en    (en[2]),
    .gres  (gres),
    .total (s3_tot)
  );

  // carry the merged totals past the divider
  grp_res_t s4_tot, s5_tot;

  always_ff @(posedge clk) begin
    if (en[3]) s4_tot <= s3_tot;
    if (en[4]) s5_tot <= s4_tot;
  end

  // ---------------------------------------------------------------------
  // Stages 4-5: mean = sum / n, toward zero
  // ---------------------------------------------------------------------
  sample_t s5_mean;

  msr_mean_div u_mean_div (
    .clk    (clk),
    .en_mul (en[3]),
    .en_fix (en[4]),
    .sum    (s3_tot.sum),
    .n      (s3_n),
    .mean   (s5_mean)
  );

  // ---------------------------------------------------------------------
  // Stage 6: result per mode, saturated; output register
  // ---------------------------------------------------------------------
  sample_t              res_next [LANES];
  logic [CNT_BITS-1:0]  vcnt_next;
  sample_t              res_q [LANES];
  logic [CNT_BITS-1:0]  vcnt_q;
  logic                 eot_q;
  logic signed [SAT_W-1:0] diff_full;

  always_comb begin
    diff_full = (SAT_W'(s5_smp[0]) <<< 1) - SAT_W'(s5_tot.sum);
    for (int i = 0; i < LANES; i++) begin
      res_next[i] = '0;
    end
    vcnt_next = CNT_BITS'(1);
    unique case (s5_mode)
      MODE_DEBIAS: begin
        for (int i = 0; i < LANES; i++) begin
          if (N_W'(i) < s5_n) begin
            res_next[i] = sat_sample(SAT_W'(s5_smp[i]) - SAT_W'(s5_mean));
          end
        end
        vcnt_next = s5_n[CNT_BITS-1:0];
      end
      MODE_MEAN: res_next[0] = s5_mean;
      MODE_MIN:  res_next[0] = s5_tot.mn;
      MODE_MAX:  res_next[0] = s5_tot.mx;
      MODE_DIFF: res_next[0] = sat_sample(diff_full);
      default:   ;  // undefined mode codes: all lanes zero
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      res_q  <= res_next;
      vcnt_q <= vcnt_next;
      eot_q  <= s5_eot;
    end
  end

  assign out_value_0   = res_q[0];
  assign out_value_1   = res_q[1];
  assign out_value_2   = res_q[2];
  assign out_value_3   = res_q[3];
  assign out_value_4   = res_q[4];
  assign out_value_5   = res_q[5];
  assign out_value_6   = res_q[6];
  assign out_value_7   = res_q[7];
  assign values_valid  = vcnt_q;
  assign end_of_output = eot_q;

endmodule

@@ verif/tb_multitrace_sample_reduction.sv @@
// Self-checking testbench for multitrace_sample_reduction: random sample columns
// under every mode, checked against an in-bench column reducer.
// Depends on msr_pkg and the multitrace_sample_reduction RTL.
`timescale 1ns / 1ps

module tb_multitrace_sample_reduction import msr_pkg::*;;

  // mode codes the block leaves unused; they still give one result
  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  localparam int PIPE_DEPTH     = 5;     // transfer-in to result offered
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
  localparam int PHASE_ITEMS    = 80;

  typedef struct packed {
    logic [LANES-1:0][SAMPLE_BITS-1:0] smp;
    logic [CNT_BITS-1:0]               cnt;
    logic                              eot;
  } column_t;

  typedef struct packed {
    logic [LANES-1:0][SAMPLE_BITS-1:0] val;
    logic [CNT_BITS-1:0]               nvalid;
    logic                              eot;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [MODE_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  column_t drv_col = '0;

  logic in_ready, out_valid;
  logic [SAMPLE_BITS-1:0] out_value_0, out_value_1, out_value_2, out_value_3;
  logic [SAMPLE_BITS-1:0] out_value_4, out_value_5, out_value_6, out_value_7;
  logic [CNT_BITS-1:0] values_valid;
  logic end_of_output;

  multitrace_sample_reduction dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .lane_sample_0 (drv_col.smp[0]),
    .lane_sample_1 (drv_col.smp[1]),
    .lane_sample_2 (drv_col.smp[2]),
    .lane_sample_3 (drv_col.smp[3]),
    .lane_sample_4 (drv_col.smp[4]),
    .lane_sample_5 (drv_col.smp[5]),
    .lane_sample_6 (drv_col.smp[6]),
    .lane_sample_7 (drv_col.smp[7]),
    .traces_in_use (drv_col.cnt),
    .end_of_trace  (drv_col.eot),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value_0   (out_value_0),
    .out_value_1   (out_value_1),
    .out_value_2   (out_value_2),
    .out_value_3   (out_value_3),
    .out_value_4   (out_value_4),
    .out_value_5   (out_value_5),
    .out_value_6   (out_value_6),
    .out_value_7   (out_value_7),
    .values_valid  (values_valid),
    .end_of_output (end_of_output)
  );

  column_t pending_cols [$];       // columns waiting for the driver
  result_t expected_results [$];   // predictions for transfers already taken
  logic [MODE_W-1:0] mode_copy;    // our view of the mode register
  logic in_taken = 1'b0;           // input transfer at the last rising edge
  int mismatches = 0;
  int idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // Column reducer: exact 64-bit sums, mean truncates toward zero, then clip.
  // ---------------------------------------------------------------------------
  function automatic sample_t clip_sample(longint v);
    longint top;
    top = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    if (v > top) return sample_t'(top);
    if (v < -top - 1) return sample_t'(-top - 1);
    return sample_t'(v);
  endfunction

  function automatic result_t reduce_column(column_t c, logic [MODE_W-1:0] m);
    longint s [LANES];
    longint acc;
    longint n;
    result_t r;
    for (int i = 0; i < LANES; i++) s[i] = sample_t'(c.smp[i]);
    n = c.cnt;
    if (n == 0) n = 1;               // zero count reads as one trace
    if (n > LANES) n = LANES;        // oversize count clamps to all lanes
    r = '0;
    r.nvalid = CNT_BITS'(1);
    r.eot = c.eot;
    case (m)
      MODE_DEBIAS, MODE_MEAN: begin
        acc = 0;
        for (int i = 0; i < n; i++) acc += s[i];
        acc = acc / n;
        if (m == MODE_MEAN) begin
          r.val[0] = clip_sample(acc);
        end else begin
          for (int i = 0; i < n; i++) r.val[i] = clip_sample(s[i] - acc);
          r.nvalid = CNT_BITS'(n);
        end
      end
      MODE_MIN: begin
        acc = s[0];
        for (int i = 1; i < n; i++) if (s[i] < acc) acc = s[i];
        r.val[0] = clip_sample(acc);
      end
      MODE_MAX: begin
        acc = s[0];
        for (int i = 1; i < n; i++) if (s[i] > acc) acc = s[i];
        r.val[0] = clip_sample(acc);
      end
      MODE_DIFF: begin
        acc = s[0];
        for (int i = 1; i < n; i++) acc -= s[i];
        r.val[0] = clip_sample(acc);
      end
      default: ;                     // spare codes: all lanes zero
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX_C;
      1: return SAMPLE_MIN_C;
      2, 3: return sample_t'($signed($urandom_range(0, 200)) - 100);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic column_t random_column();
    column_t c;
    for (int i = 0; i < LANES; i++) c.smp[i] = pick_sample();
    // mostly legal counts; now and then zero or above the lane count
    if ($urandom_range(0, 9) < 8) c.cnt = CNT_BITS'($urandom_range(1, LANES));
    else c.cnt = CNT_BITS'($urandom_range(0, 15));
    c.eot = ($urandom_range(0, 7) == 0);
    return c;
  endfunction

  function automatic column_t split_column(sample_t lane0, sample_t rest, int cnt, bit eot);
    column_t c;
    c.smp[0] = lane0;
    for (int i = 1; i < LANES; i++) c.smp[i] = rest;
    c.cnt = CNT_BITS'(cnt);
    c.eot = eot;
    return c;
  endfunction

  // checked at the rising edge, where driver and queues are settled
  task automatic wait_drained();
    while (pending_cols.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // mode changes only with the pipeline empty
  task automatic write_mode(logic [MODE_W-1:0] m);
    wait_drained();
    repeat (PIPE_DEPTH + 2) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic flag_mismatch(string field, logic signed [31:0] want,
                               logic signed [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of transfers with random gaps; now and then it holds off
  // until every result in flight has come back.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;
  bit drain_wait = 1'b0;

  always @(negedge clk) begin : col_driver
    logic nxt_valid;
    nxt_valid = in_valid;
    if (rst) begin
      nxt_valid = 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      nxt_valid = 1'b0;
      if (drain_wait) begin
        if (expected_results.size() == 0) drain_wait = 1'b0;
      end else if (burst_left == 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(40, 120);   // back to back
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = $urandom_range(1, 6);
          drain_wait = ($urandom_range(0, 39) == 0);
        end
      end
      if (!drain_wait && burst_left > 0 && pending_cols.size() != 0) begin
        drv_col <= pending_cols.pop_front();
        nxt_valid = 1'b1;
        burst_left--;
      end
    end
    in_valid <= nxt_valid;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern switches between free flow, light and heavy
  // random stalls, and long holds.
  // ---------------------------------------------------------------------------
  int stall_kind = 0;
  int stall_span = 0;

  always @(negedge clk) begin : sink_pattern
    logic nxt_ready;
    if (stall_span == 0) begin
      stall_kind = $urandom_range(0, 3);
      stall_span = $urandom_range(8, 64);
    end else begin
      stall_span--;
    end
    case (stall_kind)
      0: nxt_ready = 1'b1;
      1: nxt_ready = ($urandom_range(0, 3) != 0);
      2: nxt_ready = ($urandom_range(0, 3) == 0);
      default: nxt_ready = (stall_span < 2);
    endcase
    out_ready <= nxt_ready;
  end

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard: checks each output transfer against the oldest
  // prediction, predicts each input transfer, and runs the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    result_t got;
    result_t want;
    if (rst) begin
      mode_copy <= MODE_DEBIAS;
      in_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (cfg_wr_en) mode_copy <= cfg_wr_data;
      if (out_valid && out_ready) begin
        got.val = {out_value_7, out_value_6, out_value_5, out_value_4,
                   out_value_3, out_value_2, out_value_1, out_value_0};
        got.nvalid = values_valid;
        got.eot = end_of_output;
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected result, out_value_0", 0, sample_t'(got.val[0]));
        end else begin
          want = expected_results.pop_front();
          for (int i = 0; i < LANES; i++)
            if (got.val[i] !== want.val[i])
              flag_mismatch($sformatf("out_value_%0d", i), sample_t'(want.val[i]),
                            sample_t'(got.val[i]));
          if (got.nvalid !== want.nvalid)
            flag_mismatch("values_valid", {28'd0, want.nvalid}, {28'd0, got.nvalid});
          if (got.eot !== want.eot)
            flag_mismatch("end_of_output", {31'd0, want.eot}, {31'd0, got.eot});
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(reduce_column(drv_col, mode_copy));
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("multitrace_sample_reduction test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    logic [MODE_W-1:0] all_modes [8];
    logic [MODE_W-1:0] run_plan [10];
    all_modes = '{MODE_DEBIAS, MODE_MEAN, MODE_MIN, MODE_MAX, MODE_DIFF,
                  MODE_SPARE_5, MODE_SPARE_6, MODE_SPARE_7};
    run_plan = '{MODE_DEBIAS, MODE_DIFF, MODE_MEAN, MODE_SPARE_7, MODE_MIN,
                 MODE_MAX, MODE_DEBIAS, MODE_DEBIAS, MODE_DEBIAS, MODE_DIFF};
    run_plan[6] = MODE_W'($urandom_range(0, 7));
    run_plan[7] = MODE_W'($urandom_range(0, 7));

    @(negedge clk);
    while (rst) @(negedge clk);

    // directed: each mode sees full-scale spreads (debias and diff overflow),
    // an oversize trace count, and a zero trace count
    foreach (all_modes[k]) begin
      write_mode(all_modes[k]);
      pending_cols.push_back(split_column(SAMPLE_MAX_C, SAMPLE_MIN_C, LANES, 1'b1));
      pending_cols.push_back(split_column(SAMPLE_MIN_C, SAMPLE_MAX_C, 15, 1'b0));
      pending_cols.push_back(split_column(pick_sample(), pick_sample(), 0, 1'b1));
    end

    // random phases, one mode each, ending back on debias and diff
    foreach (run_plan[k]) begin
      write_mode(run_plan[k]);
      repeat (PHASE_ITEMS) pending_cols.push_back(random_column());
    end

    wait_drained();
    repeat (PIPE_DEPTH + 6) @(negedge clk);
    if (mismatches == 0) begin
      $display("multitrace_sample_reduction test passed");
    end else begin
      $display("multitrace_sample_reduction test failed");
    end
    $finish;
  end

endmodule
